// ===== rtl/bba_pkg.sv =====
// Shared constants, types and helpers for the buddy block allocator.
package bba_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int MIN_BLOCK    = 32;
    localparam int HEADER_BYTES = 24;
    localparam int NUM_ORDERS   = 11;

    localparam int ADDR_W    = 16;
    localparam int NEED_W    = ADDR_W + 1;
    localparam int MIN_SHIFT = $clog2(MIN_BLOCK);
    localparam int GRANULES  = HEAP_BYTES / MIN_BLOCK;
    localparam int GRAN_W    = $clog2(GRANULES);
    localparam int TOP_ORDER = NUM_ORDERS - 1;
    localparam int TOP_GRAN  = 1 << TOP_ORDER;
    localparam int TOP_BYTES = MIN_BLOCK * TOP_GRAN;
    localparam int NUM_TOP   = GRANULES / TOP_GRAN;
    localparam int ORD_W     = 4;
    localparam int ORD_IDX_W = $clog2(NUM_ORDERS);
    localparam int CNT_W     = 12;
    localparam int STAT_W    = ORD_W + 2;

    typedef logic [GRAN_W-1:0] gran_t;
    typedef logic [ORD_W-1:0]  ord_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [STAT_W-1:0] blk_stat_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_BLOCK  = 2'd1,
        STS_TOO_LARGE = 2'd2,
        STS_BAD_FREE  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        status_t           status;
    } rsp_t;

    function automatic blk_stat_t mk_stat(input logic start, input logic used, input ord_t ord);
        mk_stat = {start, used, ord};
    endfunction

endpackage

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator top level: sequencer, free lists and status memories.
// Errors found at accept report in the next cycle, a free of an unallocated block from
// S_F_CHK. Allocate runs S_A_RD, S_A_UNL, then S_A_SPLIT per split and to finish; free
// loops S_F_LOOP and S_F_BCHK per merge until a busy buddy or top order, then S_F_FIN.
// One request at a time; busy stays high until the result strobe is issued. After reset
// a clearing pass writes status and links, one granule per cycle, busy high.
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    typedef enum logic [9:0] {
        S_INIT    = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_A_RD    = 10'b0000000100,
        S_A_UNL   = 10'b0000001000,
        S_A_SPLIT = 10'b0000010000,
        S_F_RD    = 10'b0000100000,
        S_F_CHK   = 10'b0001000000,
        S_F_LOOP  = 10'b0010000000,
        S_F_BCHK  = 10'b0100000000,
        S_F_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    gran_t  head_reg [NUM_ORDERS];
    gran_t  head_next[NUM_ORDERS];
    gran_t  tail_reg [NUM_ORDERS];
    gran_t  tail_next[NUM_ORDERS];
    cnt_t   cnt_reg  [NUM_ORDERS];
    cnt_t   cnt_next [NUM_ORDERS];
    gran_t  g_reg, g_next;
    gran_t  b_reg, b_next;
    ord_t   ord_reg, ord_next;
    ord_t   k_reg, k_next;
    ord_t   i_reg, i_next;
    gran_t  clr_reg, clr_next;
    logic   done_reg, done_next;
    rsp_t   result_reg, result_next;

    logic      st_we;
    gran_t     st_waddr, st_raddr;
    blk_stat_t st_wdata, st_rdata;
    logic      nx_we;
    gran_t     nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic      pv_we;
    gran_t     pv_waddr, pv_wdata, pv_raddr, pv_rdata;

    bba_ram #(.WIDTH(STAT_W), .DEPTH(GRANULES)) u_stat_ram (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    bba_ram #(.WIDTH(GRAN_W), .DEPTH(GRANULES)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );

    bba_ram #(.WIDTH(GRAN_W), .DEPTH(GRANULES)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(pv_raddr), .rdata(pv_rdata)
    );

    always_comb
    begin
        logic [NEED_W-1:0] need;
        logic [ADDR_W-1:0] off;
        ord_t              k;
        ord_t              fit;
        logic              found;
        ord_t              o;
        gran_t             up;
        gran_t             b;

        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        g_next      = g_reg;
        b_next      = b_reg;
        ord_next    = ord_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        st_we    = 1'b0;
        st_waddr = g_reg;
        st_wdata = '0;
        st_raddr = g_reg;
        nx_we    = 1'b0;
        nx_waddr = g_reg;
        nx_wdata = g_reg;
        nx_raddr = g_reg;
        pv_we    = 1'b0;
        pv_waddr = g_reg;
        pv_wdata = g_reg;
        pv_raddr = g_reg;

        need  = {1'b0, request.request_bytes} + NEED_W'(HEADER_BYTES);
        off   = request.free_address - ADDR_W'(HEADER_BYTES);
        k     = '0;
        fit   = '0;
        found = 1'b0;
        for (int j = 0; j < NUM_ORDERS; j++)
        begin
            if ((NEED_W'(MIN_BLOCK) << j) < need)
            begin
                k = k + ord_t'(1);
            end
        end
        for (int j = NUM_ORDERS - 1; j >= 0; j--)
        begin
            if (ord_t'(j) >= k && cnt_reg[j] != '0)
            begin
                fit   = ord_t'(j);
                found = 1'b1;
            end
        end
        o  = i_reg - ord_t'(1);
        up = g_reg + (gran_t'(1) << o);
        b  = g_reg ^ (gran_t'(1) << ord_reg);

        unique case (state_reg)
            S_INIT:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = (clr_reg[TOP_ORDER-1:0] == '0) ?
                           mk_stat(1'b1, 1'b0, ord_t'(TOP_ORDER)) : '0;
                if (clr_reg[TOP_ORDER-1:0] == '0)
                begin
                    nx_we    = 1'b1;
                    nx_waddr = clr_reg;
                    nx_wdata = clr_reg + gran_t'(TOP_GRAN);
                    pv_we    = 1'b1;
                    pv_waddr = clr_reg;
                    pv_wdata = clr_reg - gran_t'(TOP_GRAN);
                end
                clr_next = clr_reg + gran_t'(1);
                if (clr_reg == gran_t'(GRANULES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    result_next.result_address = '0;
                    if (request.command == CMD_ALLOC)
                    begin
                        if (need > NEED_W'(TOP_BYTES))
                        begin
                            done_next          = 1'b1;
                            result_next.status = STS_TOO_LARGE;
                        end
                        else if (!found)
                        begin
                            done_next          = 1'b1;
                            result_next.status = STS_NO_BLOCK;
                        end
                        else
                        begin
                            g_next     = head_reg[ORD_IDX_W'(fit)];
                            i_next     = fit;
                            k_next     = k;
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        if (request.free_address < ADDR_W'(HEADER_BYTES) ||
                            off[MIN_SHIFT-1:0] != '0)
                        begin
                            done_next          = 1'b1;
                            result_next.status = STS_BAD_FREE;
                        end
                        else
                        begin
                            g_next     = off[MIN_SHIFT +: GRAN_W];
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD:
            begin
                nx_raddr   = g_reg;
                state_next = S_A_UNL;
            end
            S_A_UNL:
            begin
                head_next[ORD_IDX_W'(i_reg)] = nx_rdata;
                cnt_next[ORD_IDX_W'(i_reg)]  = cnt_reg[ORD_IDX_W'(i_reg)] - cnt_t'(1);
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT:
            begin
                st_we = 1'b1;
                if (i_reg > k_reg)
                begin
                    st_waddr = up;
                    st_wdata = mk_stat(1'b1, 1'b0, o);
                    if (cnt_reg[ORD_IDX_W'(o)] == '0)
                    begin
                        head_next[ORD_IDX_W'(o)] = up;
                    end
                    else
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = tail_reg[ORD_IDX_W'(o)];
                        nx_wdata = up;
                        pv_we    = 1'b1;
                        pv_waddr = up;
                        pv_wdata = tail_reg[ORD_IDX_W'(o)];
                    end
                    tail_next[ORD_IDX_W'(o)] = up;
                    cnt_next[ORD_IDX_W'(o)]  = cnt_reg[ORD_IDX_W'(o)] + cnt_t'(1);
                    i_next = o;
                end
                else
                begin
                    st_waddr    = g_reg;
                    st_wdata    = mk_stat(1'b1, 1'b1, k_reg);
                    done_next   = 1'b1;
                    result_next.result_address =
                        {g_reg, MIN_SHIFT'(0)} + ADDR_W'(HEADER_BYTES);
                    result_next.status = STS_OK;
                    state_next  = S_IDLE;
                end
            end
            S_F_RD:
            begin
                st_raddr   = g_reg;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (st_rdata[STAT_W-1 -: 2] != 2'b11)
                begin
                    done_next          = 1'b1;
                    result_next.status = STS_BAD_FREE;
                    state_next         = S_IDLE;
                end
                else
                begin
                    ord_next   = st_rdata[ORD_W-1:0];
                    state_next = S_F_LOOP;
                end
            end
            S_F_LOOP:
            begin
                if (ord_reg < ord_t'(TOP_ORDER))
                begin
                    st_raddr   = b;
                    nx_raddr   = b;
                    pv_raddr   = b;
                    b_next     = b;
                    state_next = S_F_BCHK;
                end
                else
                begin
                    state_next = S_F_FIN;
                end
            end
            S_F_BCHK:
            begin
                if (st_rdata != mk_stat(1'b1, 1'b0, ord_reg))
                begin
                    state_next = S_F_FIN;
                end
                else
                begin
                    if (head_reg[ORD_IDX_W'(ord_reg)] == b_reg)
                    begin
                        head_next[ORD_IDX_W'(ord_reg)] = nx_rdata;
                    end
                    else
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = pv_rdata;
                        nx_wdata = nx_rdata;
                    end
                    if (tail_reg[ORD_IDX_W'(ord_reg)] == b_reg)
                    begin
                        tail_next[ORD_IDX_W'(ord_reg)] = pv_rdata;
                    end
                    else
                    begin
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata;
                        pv_wdata = pv_rdata;
                    end
                    if (cnt_reg[ORD_IDX_W'(ord_reg)] != '0)
                    begin
                        cnt_next[ORD_IDX_W'(ord_reg)] =
                            cnt_reg[ORD_IDX_W'(ord_reg)] - cnt_t'(1);
                    end
                    st_we    = 1'b1;
                    st_wdata = '0;
                    if (b_reg < g_reg)
                    begin
                        st_waddr = g_reg;
                        g_next   = b_reg;
                    end
                    else
                    begin
                        st_waddr = b_reg;
                    end
                    ord_next   = ord_reg + ord_t'(1);
                    state_next = S_F_LOOP;
                end
            end
            S_F_FIN:
            begin
                st_we    = 1'b1;
                st_waddr = g_reg;
                st_wdata = mk_stat(1'b1, 1'b0, ord_reg);
                if (cnt_reg[ORD_IDX_W'(ord_reg)] == '0)
                begin
                    head_next[ORD_IDX_W'(ord_reg)] = g_reg;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = tail_reg[ORD_IDX_W'(ord_reg)];
                    nx_wdata = g_reg;
                    pv_we    = 1'b1;
                    pv_waddr = g_reg;
                    pv_wdata = tail_reg[ORD_IDX_W'(ord_reg)];
                end
                tail_next[ORD_IDX_W'(ord_reg)] = g_reg;
                cnt_next[ORD_IDX_W'(ord_reg)]  =
                    cnt_reg[ORD_IDX_W'(ord_reg)] + cnt_t'(1);
                done_next   = 1'b1;
                result_next = '{result_address: '0, status: STS_OK};
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            for (int j = 0; j < NUM_ORDERS; j++)
            begin
                head_reg[j] <= '0;
                tail_reg[j] <= (j == TOP_ORDER) ? gran_t'(GRANULES - TOP_GRAN) : '0;
                cnt_reg[j]  <= (j == TOP_ORDER) ? cnt_t'(NUM_TOP) : '0;
            end
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg   <= g_next;
        b_reg   <= b_next;
        ord_reg <= ord_next;
        k_reg   <= k_next;
        i_reg   <= i_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STS_OK) |-> result.result_address == '0)
        else $error("error result carries an address");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result without a request in progress");

    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> busy && !done)
        else $error("request possible during clearing pass");

endmodule

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
